### rtl/ffha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;
	localparam int HEAP_BYTES     = 4096;
	localparam int ALIGN_BYTES    = 4;
	localparam int HEADER_BYTES   = 12;
	localparam int MIN_DATA_BYTES = 12;
	localparam int HS             = (HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int OFF_W          = 13;
	localparam int ADDR_W         = 12;
	localparam int DEPTH          = 4096;
	localparam int ENT_W          = 2 + 2 * OFF_W;

	localparam logic [1:0] K_NONE = 2'd0;
	localparam logic [1:0] K_SENT = 2'd1;
	localparam logic [1:0] K_FREE = 2'd2;
	localparam logic [1:0] K_USED = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_NULL   = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [OFF_W-1:0] nxt;
		logic [OFF_W-1:0] prv;
	} hdr_t;
endpackage
`default_nettype wire

### rtl/first_fit_heap_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over a header memory, with merge on release.
// ----------------------------------------------------------------------------
// Null and out-of-range releases go straight to the result; other releases read
//   the header, are rejected unless it is in use, else read both neighbours and
//   rewrite headers, a merge into the next block also fixing the one after.
//   Allocate walks headers from lowest-free, writes (more with a split), then
//   rescans when lowest-free moves. Throughput: one item at a time; a result waiting
//   on m_tready holds the next item at its result step. Reset: a clearing pass writes
//   every entry (sentinels, one free block, empty elsewhere) before the first beat.
module first_fit_heap_allocator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // req_size[15:0], block_offset[31:16]
	input  wire logic        s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // ok[0], data_offset[12:1], status[14:13]
);
	import ffha_pkg::*;

	localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_ARD  = 5'd2,
		S_AEV  = 5'd3,  S_AW1  = 5'd4,  S_AR2  = 5'd5,  S_AW2  = 5'd6,
		S_AW3  = 5'd7,  S_LRD  = 5'd8,  S_LEV  = 5'd9,  S_RRD  = 5'd10,
		S_REV  = 5'd11, S_PRD  = 5'd12, S_PEV  = 5'd13, S_NRD  = 5'd14,
		S_NEV  = 5'd15, S_W1   = 5'd16, S_W2   = 5'd17, S_W3   = 5'd18,
		S_NNR  = 5'd19, S_NNE  = 5'd20, S_OUT  = 5'd21, S_MRD  = 5'd22,
		S_MWR  = 5'd23;

	logic [4:0]        st_q;
	logic [OFF_W-1:0]  cur_q, lf_q, need_q, nx_q, pv_q, blk_q, clr_q;
	hdr_t              cur_h_q, pv_h_q, nx_h_q;
	logic              pmerge_q;
	logic              ok_q;
	logic [11:0]       doff_q;
	logic [1:0]        stat_q;

	logic              we;
	logic [OFF_W-1:0]  ad;
	hdr_t              wd, rd;
	logic [ENT_W-1:0]  rd_raw;

	ffha_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_hdr (
		.clk(clk), .we(we), .addr(ad[ADDR_W-1:0]), .wdata(wd), .rdata(rd_raw)
	);
	assign rd = hdr_t'(rd_raw);

	localparam logic [OFF_W-1:0] HSV  = OFF_W'(HS);
	localparam logic [OFF_W-1:0] HDR  = OFF_W'(HEADER_BYTES);
	localparam logic [OFF_W-1:0] ENDP = OFF_W'(HS - HEADER_BYTES);
	localparam logic [OFF_W-1:0] SPLT = OFF_W'(HEADER_BYTES + MIN_DATA_BYTES);

	logic [16:0] rnd;
	logic [17:0] need_w;
	logic [15:0] bo;
	logic [OFF_W-1:0] span;
	logic [OFF_W-1:0] blk_fin;
	logic nmerge;
	assign bo = s_tdata[31:16];
	assign rnd = ((17'(s_tdata[15:0]) + 17'(ALIGN_BYTES - 1)) / 17'(ALIGN_BYTES))
		* 17'(ALIGN_BYTES);
	assign need_w = 18'(rnd) + 18'(HEADER_BYTES);
	assign span = cur_h_q.nxt - cur_q;

	// release: surviving block after a merge with the previous one, next-side merge
	assign blk_fin = pmerge_q ? pv_q : blk_q;
	assign nmerge = nx_q < HSV && nx_h_q.kind == K_FREE && nx_q != blk_fin;

	// Memory port steering
	always_comb begin
		we = 1'b0;
		ad = cur_q;
		wd = cur_h_q;
		unique case (st_q)
			S_CLR: begin
				we = 1'b1;
				ad = clr_q;
				wd = '{K_NONE, '0, '0};
				if (clr_q == '0) wd = '{K_SENT, HDR, '0};
				else if (clr_q == HDR) wd = '{K_FREE, ENDP, '0};
				else if (clr_q == ENDP) wd = '{K_SENT, HSV, HDR};
			end
			S_ARD, S_LRD, S_RRD, S_NNR: ad = cur_q;
			S_AW1: begin
				we = 1'b1; ad = cur_q;
				wd = cur_h_q; wd.kind = K_USED;
				if (span - need_q >= SPLT) wd.nxt = cur_q + need_q;
			end
			S_AR2: ad = cur_h_q.nxt;
			S_AW2: begin
				we = 1'b1; ad = cur_q + need_q;
				wd = '{K_FREE, cur_h_q.nxt, cur_q};
			end
			S_AW3: begin
				we = cur_h_q.nxt < HSV; ad = cur_h_q.nxt;
				wd = nx_h_q; wd.prv = cur_q + need_q;
			end
			S_PRD: ad = pv_q;
			S_NRD: ad = nx_q;
			S_W1: begin
				we = 1'b1; ad = blk_q;
				wd = cur_h_q; wd.kind = pmerge_q ? K_NONE : K_FREE;
				if (nmerge && !pmerge_q) wd.nxt = nx_h_q.nxt;
			end
			S_W2: begin
				we = pmerge_q; ad = pv_q;
				wd = pv_h_q; wd.nxt = nmerge ? nx_h_q.nxt : nx_q;
			end
			S_W3: begin
				we = (pmerge_q || nmerge) && nx_q < HSV; ad = nx_q;
				wd = nx_h_q;
				if (pmerge_q) wd.prv = pv_q;
				if (nmerge) wd.kind = K_NONE;
			end
			S_MRD: ad = nx_h_q.nxt;
			S_MWR: begin
				we = nx_h_q.nxt < HSV; ad = nx_h_q.nxt;
				wd = rd; wd.prv = blk_fin;
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			lf_q <= HDR;
		end else begin
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HSV - 1'b1) st_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid) begin
					ok_q <= 1'b0; doff_q <= '0;
					if (!s_tuser) begin
						need_q <= need_w > 18'(HS) ? HSV + 1'b1 : OFF_W'(need_w);
						cur_q <= lf_q;
						stat_q <= ST_NOFIT;
						st_q <= lf_q < HSV ? S_ARD : S_OUT;
					end else if (bo == '0) begin
						stat_q <= ST_NULL; st_q <= S_OUT;
					end else if (bo < 16'(HEADER_BYTES) ||
						(17'(bo) - 17'(HEADER_BYTES)) >= 17'(HS)) begin
						stat_q <= ST_REJECT; st_q <= S_OUT;
					end else begin
						cur_q <= OFF_W'(bo - 16'(HEADER_BYTES));
						stat_q <= ST_REJECT;
						st_q <= S_RRD;
					end
				end
				S_ARD: st_q <= S_AEV;
				S_AEV: begin
					cur_h_q <= rd;
					st_q <= S_AW1;
					if (rd.nxt <= cur_q) st_q <= S_OUT;
					else if (!(rd.kind == K_FREE && (rd.nxt - cur_q) >= need_q)) begin
						cur_q <= rd.nxt;
						st_q <= rd.nxt < HSV ? S_ARD : S_OUT;
					end
				end
				S_AW1: begin
					ok_q <= 1'b1; stat_q <= ST_DONE;
					doff_q <= 12'(cur_q + HDR);
					if (span - need_q >= SPLT) st_q <= S_AR2;
					else st_q <= S_LRD;
					blk_q <= cur_q;
				end
				S_AR2: st_q <= S_AW2;
				S_AW2: begin nx_h_q <= rd; st_q <= S_AW3; end
				S_AW3: begin
					st_q <= S_LRD;
				end
				S_LRD: begin
					if (blk_q != lf_q) st_q <= S_OUT;
					else begin
						cur_q <= lf_q;
						st_q <= S_LEV;
					end
				end
				S_LEV: st_q <= S_NNE;
				S_NNE: begin
					if (rd.kind == K_FREE) begin
						lf_q <= cur_q; st_q <= S_OUT;
					end else begin
						cur_q <= rd.nxt > cur_q ? rd.nxt : HSV;
						if (rd.nxt > cur_q && rd.nxt < HSV) st_q <= S_NNR;
						else begin lf_q <= HSV; st_q <= S_OUT; end
					end
				end
				S_NNR: st_q <= S_LEV;
				S_RRD: st_q <= S_REV;
				S_REV: begin
					cur_h_q <= rd;
					blk_q <= cur_q;
					pv_q <= rd.prv; nx_q <= rd.nxt;
					if (rd.kind != K_USED) st_q <= S_OUT;
					else st_q <= S_PRD;
				end
				S_PRD: st_q <= S_PEV;
				S_PEV: begin
					pv_h_q <= rd;
					pmerge_q <= pv_q < HSV && rd.kind == K_FREE && pv_q != blk_q;
					st_q <= S_NRD;
				end
				S_NRD: st_q <= S_NEV;
				S_NEV: begin
					nx_h_q <= rd;
					st_q <= S_W1;
				end
				S_W1: st_q <= S_W2;
				S_W2: st_q <= S_W3;
				S_W3: begin
					// merged block is complete; pull lowest-free down to it
					ok_q <= 1'b1; stat_q <= ST_DONE;
					if (lf_q > blk_fin) lf_q <= blk_fin;
					st_q <= nmerge ? S_MRD : S_OUT;
				end
				S_MRD: st_q <= S_MWR;
				S_MWR: st_q <= S_OUT;
				S_OUT: if (!m_tvalid || m_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else if (st_q == S_OUT && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
			m_tdata <= {1'b0, stat_q, doff_q, ok_q};
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign s_tready = (st_q == S_IDLE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	a_lf_range: assert property (@(posedge clk) disable iff (!arst_n)
		lf_q <= HSV);
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q <= S_MWR);
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLR |-> !s_tready);
endmodule
`default_nettype wire

### rtl/ffha_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire
